/* src/impq_pkg.sv */
// Shared constants, codes and control/status types for the indexed priority queue.
`default_nettype none
package impq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ID_SPACE = 1024;

    localparam int ITEM_W  = 10;
    localparam int PRI_W   = 32;
    localparam int SLOT_W  = $clog2(CAPACITY + 1);
    localparam int HADDR_W = $clog2(CAPACITY);
    localparam int MADDR_W = $clog2(ID_SPACE);
    localparam int HEAP_W  = ITEM_W + PRI_W;

    localparam logic [SLOT_W-1:0]  CAP_SLOTS = SLOT_W'(CAPACITY);
    localparam logic [ITEM_W:0]    ID_LIMIT  = (ITEM_W + 1)'(ID_SPACE);
    localparam logic [MADDR_W-1:0] MAP_LAST  = MADDR_W'(ID_SPACE - 1);

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_CHANGE  = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    // micro-operation issued by the controller each cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_DECODE,
        OP_EXT_TOP,
        OP_EXT_LAST,
        OP_CHECK,
        OP_UP_RD,
        OP_UP_CMP,
        OP_DN_LEFT,
        OP_DN_RIGHT,
        OP_DN_CMP,
        OP_FINISH,
        OP_EXT_CLR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_extract;
        logic is_update;
        logic is_insert;
        logic empty;
        logic bad_item;
        logic found;
        logic full;
        logic try_down;
        logic at_root;
        logic parent_less;
        logic left_over;
        logic big_self;
        logic clear_last;
    } dp_status_t;

endpackage
`default_nettype wire

/* src/indexed_max_priority_queue_top.sv */
// Top level of the indexed binary max-heap priority queue.
//
//   channel  | handshake        | words
//   ---------+------------------+--------------------------------------------
//   command  | start, busy      | command, item_id, priority_req
//   result   | done (strobe)    | out_item, out_slot, status, occupancy
//
// A command sifts up (insert, raised priority) or down (extract, lowered
// priority) by L levels, up to log2 of capacity. Each level is a compare and
// move after one heap memory read going up, after two going down.
// After reset the slot map is cleared, one entry at a time, with busy high.
// The result word is on the ports in the cycle that done is high and stays
// until the next command is taken. busy falls in the cycle that done is high, so the next command may start there.
`default_nettype none
module indexed_max_priority_queue_top import impq_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              command,
    input  wire logic [ITEM_W-1:0]       item_id,
    input  wire logic signed [PRI_W-1:0] priority_req,
    output logic                         done,
    output logic [ITEM_W-1:0]            out_item,
    output logic [SLOT_W-1:0]            out_slot,
    output logic [1:0]                   status,
    output logic [SLOT_W-1:0]            occupancy
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_sts;

    impq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (dp_sts),
        .cmd   (dp_cmd),
        .busy  (busy),
        .done  (done)
    );

    impq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .sts          (dp_sts),
        .command      (command),
        .item_id      (item_id),
        .priority_req (priority_req),
        .out_item     (out_item),
        .out_slot     (out_slot),
        .status       (status),
        .occupancy    (occupancy)
    );

`ifndef SYNTH
    // an accepted command always raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // a result strobe comes with readiness for the next command
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while result strobe high");

    // occupancy never exceeds capacity
    a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> occupancy <= CAP_SLOTS)
        else $error("occupancy beyond capacity");

    // a full report only when the heap is actually full
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> occupancy == CAP_SLOTS)
        else $error("full reported below capacity");
`endif

endmodule
`default_nettype wire

/* src/impq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module impq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/impq_dp.sv */
// Datapath: heap and slot map memories, sift registers, counters and result registers.
`default_nettype none
module impq_dp import impq_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    output dp_status_t               sts,
    input  wire logic [1:0]          command,
    input  wire logic [ITEM_W-1:0]   item_id,
    input  wire logic signed [PRI_W-1:0] priority_req,
    output logic [ITEM_W-1:0]        out_item,
    output logic [SLOT_W-1:0]        out_slot,
    output logic [1:0]               status,
    output logic [SLOT_W-1:0]        occupancy
);

    // control registers
    logic [SLOT_W-1:0]  count_reg, count_next;
    logic [MADDR_W-1:0] clr_reg, clr_next;

    // word and sift registers
    logic [1:0]              cmd_reg, cmd_next;
    logic [ITEM_W-1:0]       mitem_reg, mitem_next;
    logic signed [PRI_W-1:0] mkey_reg, mkey_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic                    try_down_reg, try_down_next;
    logic [ITEM_W-1:0]       litem_reg, litem_next;
    logic signed [PRI_W-1:0] lpri_reg, lpri_next;
    logic [ITEM_W-1:0]       oitem_reg, oitem_next;
    logic [SLOT_W-1:0]       oslot_reg, oslot_next;
    logic [1:0]              ostat_reg, ostat_next;

    // memory ports
    logic               h_we;
    logic [HADDR_W-1:0] h_waddr, h_raddr;
    logic [HEAP_W-1:0]  h_wdata, h_rdata;
    logic               m_we;
    logic [MADDR_W-1:0] m_waddr, m_raddr;
    logic [SLOT_W-1:0]  m_wdata, m_rdata;

    impq_ram #(.WIDTH(HEAP_W), .DEPTH(CAPACITY)) u_heap (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    impq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_SPACE)) u_map (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // heap read word fields
    logic [ITEM_W-1:0]       h_item;
    logic signed [PRI_W-1:0] h_pri;
    assign h_item = h_rdata[HEAP_W-1:PRI_W];
    assign h_pri  = h_rdata[PRI_W-1:0];

    // child indices, one bit wider than a slot
    logic [SLOT_W:0] left_idx, right_idx, count_ext;
    assign left_idx  = {idx_reg, 1'b0};
    assign right_idx = left_idx + (SLOT_W + 1)'(1);
    assign count_ext = {1'b0, count_reg};

    logic [SLOT_W-1:0] parent_idx, slot_addr_base;
    assign parent_idx = idx_reg >> 1;

    // larger of node and children; the right child word is on the read port
    logic                    left_ok, right_ok, pick_left, pick_right;
    logic signed [PRI_W-1:0] best_left_pri;
    assign left_ok       = left_idx <= count_ext;
    assign right_ok      = right_idx <= count_ext;
    assign pick_left     = left_ok && (lpri_reg > mkey_reg);
    assign best_left_pri = pick_left ? lpri_reg : mkey_reg;
    assign pick_right    = right_ok && (h_pri > best_left_pri);

    logic [ITEM_W-1:0]       big_item;
    logic signed [PRI_W-1:0] big_pri;
    logic [SLOT_W-1:0]       big_idx;
    always_comb
    begin
        big_item = litem_reg;
        big_pri  = lpri_reg;
        big_idx  = left_idx[SLOT_W-1:0];
        if (pick_right)
        begin
            big_item = h_item;
            big_pri  = h_pri;
            big_idx  = right_idx[SLOT_W-1:0];
        end
    end

    assign slot_addr_base = idx_reg - SLOT_W'(1);

    // status toward the controller
    always_comb
    begin
        sts.is_extract  = cmd_reg == CMD_EXTRACT;
        sts.is_update   = (cmd_reg == CMD_INSERT) || (cmd_reg == CMD_CHANGE);
        sts.is_insert   = cmd_reg == CMD_INSERT;
        sts.empty       = count_reg == '0;
        sts.bad_item    = {1'b0, mitem_reg} >= ID_LIMIT;
        sts.found       = m_rdata != '0;
        sts.full        = count_reg >= CAP_SLOTS;
        sts.try_down    = try_down_reg;
        sts.at_root     = idx_reg == SLOT_W'(1);
        sts.parent_less = h_pri < mkey_reg;
        sts.left_over   = !left_ok;
        sts.big_self    = !(pick_left || pick_right);
        sts.clear_last  = clr_reg == MAP_LAST;
    end

    // memory port selection per micro-op
    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = slot_addr_base[HADDR_W-1:0];
        h_wdata = {mitem_reg, mkey_reg};
        h_raddr = '0;
        m_we    = 1'b0;
        m_waddr = MADDR_W'(mitem_reg);
        m_wdata = idx_reg;
        m_raddr = MADDR_W'(mitem_reg);
        case (cmd.op)
            OP_CLEAR:
            begin
                m_we    = 1'b1;
                m_waddr = clr_reg;
                m_wdata = '0;
            end
            OP_DECODE:
            begin
                h_raddr = '0;
            end
            OP_EXT_TOP:
            begin
                h_raddr = HADDR_W'(count_reg - SLOT_W'(1));
            end
            OP_UP_RD:
            begin
                h_raddr = HADDR_W'(parent_idx - SLOT_W'(1));
            end
            OP_UP_CMP:
            begin
                h_we    = sts.parent_less;
                h_wdata = h_rdata;
                m_we    = sts.parent_less;
                m_waddr = MADDR_W'(h_item);
            end
            OP_DN_LEFT:
            begin
                h_raddr = HADDR_W'(left_idx - (SLOT_W + 1)'(1));
            end
            OP_DN_RIGHT:
            begin
                h_raddr = left_idx[HADDR_W-1:0];
            end
            OP_DN_CMP:
            begin
                h_we    = !sts.big_self;
                h_wdata = {big_item, big_pri};
                m_we    = !sts.big_self;
                m_waddr = MADDR_W'(big_item);
            end
            OP_FINISH:
            begin
                h_we = 1'b1;
                m_we = 1'b1;
            end
            OP_EXT_CLR:
            begin
                m_we    = 1'b1;
                m_waddr = MADDR_W'(oitem_reg);
                m_wdata = '0;
            end
            default:
            begin
                h_we = 1'b0;
            end
        endcase
    end

    // register updates per micro-op
    always_comb
    begin
        count_next    = count_reg;
        clr_next      = clr_reg;
        cmd_next      = cmd_reg;
        mitem_next    = mitem_reg;
        mkey_next     = mkey_reg;
        idx_next      = idx_reg;
        try_down_next = try_down_reg;
        litem_next    = litem_reg;
        lpri_next     = lpri_reg;
        oitem_next    = oitem_reg;
        oslot_next    = oslot_reg;
        ostat_next    = ostat_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                clr_next = clr_reg + MADDR_W'(1);
            end
            OP_LATCH:
            begin
                cmd_next   = command;
                mitem_next = item_id;
                mkey_next  = priority_req;
                oitem_next = '0;
                oslot_next = '0;
                ostat_next = ST_OK;
            end
            OP_DECODE:
            begin
                if (sts.is_extract && sts.empty)
                begin
                    ostat_next = ST_EMPTY;
                end
                if (sts.is_update && sts.bad_item)
                begin
                    ostat_next = ST_ABSENT;
                end
            end
            OP_EXT_TOP:
            begin
                oitem_next = h_item;
            end
            OP_EXT_LAST:
            begin
                mitem_next    = h_item;
                mkey_next     = h_pri;
                count_next    = count_reg - SLOT_W'(1);
                idx_next      = SLOT_W'(1);
                try_down_next = 1'b1;
            end
            OP_CHECK:
            begin
                if (sts.found)
                begin
                    idx_next      = m_rdata;
                    try_down_next = 1'b1;
                end
                else if (cmd_reg == CMD_CHANGE)
                begin
                    ostat_next = ST_ABSENT;
                end
                else if (sts.full)
                begin
                    ostat_next = ST_FULL;
                end
                else
                begin
                    count_next    = count_reg + SLOT_W'(1);
                    idx_next      = count_reg + SLOT_W'(1);
                    try_down_next = 1'b0;
                end
            end
            OP_UP_CMP:
            begin
                if (sts.parent_less)
                begin
                    idx_next      = parent_idx;
                    try_down_next = 1'b0;
                end
            end
            OP_DN_RIGHT:
            begin
                litem_next = h_item;
                lpri_next  = h_pri;
            end
            OP_DN_CMP:
            begin
                if (!sts.big_self)
                begin
                    idx_next = big_idx;
                end
            end
            OP_FINISH:
            begin
                if (!sts.is_extract)
                begin
                    oslot_next = idx_reg;
                end
            end
            default:
            begin
                cmd_next = cmd_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        mitem_reg    <= mitem_next;
        mkey_reg     <= mkey_next;
        idx_reg      <= idx_next;
        try_down_reg <= try_down_next;
        litem_reg    <= litem_next;
        lpri_reg     <= lpri_next;
        oitem_reg    <= oitem_next;
        oslot_reg    <= oslot_next;
        ostat_reg    <= ostat_next;
    end

    assign out_item  = oitem_reg;
    assign out_slot  = oslot_reg;
    assign status    = ostat_reg;
    assign occupancy = count_reg;

endmodule
`default_nettype wire

/* src/impq_ctrl.sv */
// Controller: sequences reset clear, lookup, extract, sift up and sift down steps over the datapath.
`default_nettype none
module impq_ctrl import impq_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t sts,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DECODE   = 13'b0000000000100,
        S_EXT_TOP  = 13'b0000000001000,
        S_EXT_LAST = 13'b0000000010000,
        S_CHECK    = 13'b0000000100000,
        S_UP_RD    = 13'b0000001000000,
        S_UP_CMP   = 13'b0000010000000,
        S_DN_LEFT  = 13'b0000100000000,
        S_DN_RIGHT = 13'b0001000000000,
        S_DN_CMP   = 13'b0010000000000,
        S_FINISH   = 13'b0100000000000,
        S_EXT_CLR  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.op = OP_DECODE;
                if (sts.is_extract && !sts.empty)
                begin
                    state_next = S_EXT_TOP;
                end
                else if (sts.is_update && !sts.bad_item)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_EXT_TOP:
            begin
                cmd.op     = OP_EXT_TOP;
                state_next = S_EXT_LAST;
            end
            S_EXT_LAST:
            begin
                cmd.op     = OP_EXT_LAST;
                state_next = S_DN_LEFT;
            end
            S_CHECK:
            begin
                cmd.op = OP_CHECK;
                // queued item moves; a new item goes in only when there is room
                if (sts.found || (sts.is_insert && !sts.full))
                begin
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_UP_RD:
            begin
                cmd.op = OP_UP_RD;
                if (!sts.at_root)
                begin
                    state_next = S_UP_CMP;
                end
                else if (sts.try_down)
                begin
                    state_next = S_DN_LEFT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_UP_CMP:
            begin
                cmd.op = OP_UP_CMP;
                if (sts.parent_less)
                begin
                    state_next = S_UP_RD;
                end
                else if (sts.try_down)
                begin
                    state_next = S_DN_LEFT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DN_LEFT:
            begin
                cmd.op = OP_DN_LEFT;
                state_next = sts.left_over ? S_FINISH : S_DN_RIGHT;
            end
            S_DN_RIGHT:
            begin
                cmd.op     = OP_DN_RIGHT;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                cmd.op     = OP_DN_CMP;
                state_next = sts.big_self ? S_FINISH : S_DN_LEFT;
            end
            S_FINISH:
            begin
                cmd.op = OP_FINISH;
                if (sts.is_extract)
                begin
                    state_next = S_EXT_CLR;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_EXT_CLR:
            begin
                cmd.op     = OP_EXT_CLR;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // the result word is shown in the cycle after the last step; idle then
    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire
